[rtl/apsp_pkg.sv]
// ----------------------------------------------------------------------------
// apsp_pkg
// Types and constants shared by the all-pairs shortest path block.
// ----------------------------------------------------------------------------
`default_nettype none

package apsp_pkg;

  localparam int EDGE_W    = 16;
  localparam int DIST_W    = 24;
  localparam int VC_W      = 6;
  localparam int OP_W      = 3;
  localparam int PIDX_W    = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 24'sh7FFFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 24'sh800000;

  localparam logic [VC_W-1:0]          VC_RESET      = 6'd32;
  localparam logic signed [EDGE_W-1:0] NO_EDGE_RESET = 16'sd20;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NO_EDGE_WEIGHT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR     = 3'd0,
    OP_SET_EDGE  = 3'd1,
    OP_RUN       = 3'd2,
    OP_READ_DIST = 3'd3,
    OP_READ_EDGE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_COPY,
    S_COPY_END,
    S_ROW,
    S_RELAX,
    S_DRAIN
  } state_t;

endpackage

`default_nettype wire

[rtl/apsp_ram.sv]
// ----------------------------------------------------------------------------
// apsp_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module apsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[rtl/apsp_relax.sv]
// ----------------------------------------------------------------------------
// apsp_relax
// One relaxation: saturating sum of d[i][k] and d[k][j], min against d[i][j].
// ----------------------------------------------------------------------------
`default_nettype none

module apsp_relax (
  input  wire logic signed [apsp_pkg::DIST_W-1:0] dik,
  input  wire logic signed [apsp_pkg::DIST_W-1:0] dkj,
  input  wire logic signed [apsp_pkg::DIST_W-1:0] dij,
  output logic                                    take,
  output logic signed      [apsp_pkg::DIST_W-1:0] new_val
);
  import apsp_pkg::*;

  logic signed [DIST_W:0]   sum;
  logic signed [DIST_W-1:0] cand;

  always_comb begin
    sum = {dik[DIST_W-1], dik} + {dkj[DIST_W-1], dkj};
    // top two bits disagree on overflow
    if (sum[DIST_W:DIST_W-1] == 2'b01) begin
      cand = DIST_MAX;
    end else if (sum[DIST_W:DIST_W-1] == 2'b10) begin
      cand = DIST_MIN;
    end else begin
      cand = sum[DIST_W-1:0];
    end
    take    = cand < dij;
    new_val = take ? cand : dij;
  end

endmodule

`default_nettype wire

[rtl/all_pairs_shortest_path_top.sv]
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_top
// Floyd-Warshall all-pairs shortest path over an edge memory and a distance
// memory.
// ----------------------------------------------------------------------------
// Set-edge and both reads leave busy low and may follow each other in every
// cycle with busy low; a read's value appears on value with valid high in the
// cycle after start and cannot be held off. With n the active vertex count,
// clear keeps busy high while it writes n*n edge entries (one edge write a
// cycle), and run while it does a copy sweep of one entry a cycle, then for
// every via and source vertex a fetch of d[i][k] and one relaxation a cycle,
// bounded by the single write port of the distance memory, then a drain. A
// clear or run with n zero returns at once. The memories are not reset.
`default_nettype none

module all_pairs_shortest_path_top #(
  parameter int MAX_VERTICES = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [apsp_pkg::OP_W-1:0]             opcode,
  input  wire logic [apsp_pkg::PIDX_W-1:0]           row,
  input  wire logic [apsp_pkg::PIDX_W-1:0]           col,
  input  wire logic signed [apsp_pkg::EDGE_W-1:0]    weight,
  output logic                                       valid,
  output logic signed [apsp_pkg::DIST_W-1:0]         value,
  input  wire logic                                  cfg_we,
  input  wire logic [apsp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [apsp_pkg::CFG_W-1:0]            cfg_data
);
  import apsp_pkg::*;

  localparam int IW    = $clog2(MAX_VERTICES);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 2 ** AW;
  localparam int CW    = (IW > PIDX_W) ? IW : PIDX_W;
  localparam int NW    = (IW + 1 > VC_W) ? IW + 1 : VC_W;
  localparam logic [CW:0]   MAXV_C = (CW + 1)'(MAX_VERTICES);
  localparam logic [NW-1:0] MAXV_N = NW'(MAX_VERTICES);

  // configuration
  logic [VC_W-1:0]          vertex_count;
  logic signed [EDGE_W-1:0] no_edge_weight;

  // control
  state_t        state, state_next;
  logic [IW-1:0] via_index, via_index_next;
  logic [IW-1:0] from_index, from_index_next;
  logic [IW-1:0] to_index, to_index_next;

  // write-back stage
  logic          st_copy, st_relax, st_at_via, load_dik;
  logic [AW-1:0] st_addr;
  logic          copy_issue, relax_issue;
  logic signed [DIST_W-1:0] dik;

  // read result
  logic rd_valid, rd_dist, rd_inside;

  // memory ports
  logic              edge_we;
  logic [AW-1:0]     edge_waddr;
  logic [EDGE_W-1:0] edge_wdata;
  logic [EDGE_W-1:0] edge_rd_a, edge_rd_b;
  logic              dist_we;
  logic [AW-1:0]     dist_waddr;
  logic [DIST_W-1:0] dist_wdata;
  logic [AW-1:0]     dist_raddr_a;
  logic [DIST_W-1:0] dist_rd_a, dist_rd_b;

  logic                     relax_take;
  logic signed [DIST_W-1:0] relax_new;

  // port index handling
  logic [CW-1:0] row_ext, col_ext;
  logic          in_store;
  logic [IW-1:0] row_idx, col_idx;
  logic [NW-1:0] vc_ext, n_act;
  logic [IW-1:0] last_idx;
  logic          n_zero, accept, read_op;

  assign row_ext  = CW'(row);
  assign col_ext  = CW'(col);
  assign in_store = ({1'b0, row_ext} < MAXV_C) && ({1'b0, col_ext} < MAXV_C);
  assign row_idx  = row_ext[IW-1:0];
  assign col_idx  = col_ext[IW-1:0];
  assign vc_ext   = NW'(vertex_count);
  assign n_act    = (vc_ext > MAXV_N) ? MAXV_N : vc_ext;
  assign n_zero   = (n_act == '0);
  assign last_idx = IW'(n_act - NW'(1));
  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign read_op  = (op_t'(opcode) == OP_READ_DIST) || (op_t'(opcode) == OP_READ_EDGE);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count   <= VC_RESET;
      no_edge_weight <= NO_EDGE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_COUNT:   vertex_count   <= cfg_data[VC_W-1:0];
        REG_NO_EDGE_WEIGHT: no_edge_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      via_index  <= '0;
      from_index <= '0;
      to_index   <= '0;
      st_copy    <= 1'b0;
      st_relax   <= 1'b0;
      load_dik   <= 1'b0;
      rd_valid   <= 1'b0;
    end else begin
      state      <= state_next;
      via_index  <= via_index_next;
      from_index <= from_index_next;
      to_index   <= to_index_next;
      st_copy    <= copy_issue;
      st_relax   <= relax_issue;
      load_dik   <= (state == S_ROW);
      rd_valid   <= accept && read_op;
    end
  end

  always_ff @(posedge clk) begin
    st_addr   <= {from_index, to_index};
    st_at_via <= (to_index == via_index);
    rd_dist   <= (op_t'(opcode) == OP_READ_DIST);
    rd_inside <= in_store;
    // d[i][k] changes within the row when j reaches k
    if (load_dik) begin
      dik <= $signed(dist_rd_a);
    end else if (st_relax && st_at_via) begin
      dik <= relax_new;
    end
  end

  always_comb begin
    state_next      = state;
    via_index_next  = via_index;
    from_index_next = from_index;
    to_index_next   = to_index;
    copy_issue      = 1'b0;
    relax_issue     = 1'b0;
    edge_we         = 1'b0;
    edge_waddr      = {row_idx, col_idx};
    edge_wdata      = weight;
    dist_raddr_a    = {row_idx, col_idx};
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(opcode))
            OP_CLEAR: begin
              if (!n_zero) begin
                state_next = S_CLEAR;
              end
            end
            OP_SET_EDGE: begin
              edge_we = in_store;
            end
            OP_RUN: begin
              if (!n_zero) begin
                state_next = S_COPY;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLEAR, S_COPY: begin
        if (state == S_CLEAR) begin
          edge_we    = 1'b1;
          edge_waddr = {from_index, to_index};
          edge_wdata = (from_index == to_index) ? '0 : no_edge_weight;
        end else begin
          copy_issue = 1'b1;
        end
        if (to_index == last_idx) begin
          to_index_next = '0;
          if (from_index == last_idx) begin
            from_index_next = '0;
            state_next      = (state == S_CLEAR) ? S_IDLE : S_COPY_END;
          end else begin
            from_index_next = from_index + 1'b1;
          end
        end else begin
          to_index_next = to_index + 1'b1;
        end
      end
      S_COPY_END: begin
        state_next = S_ROW;
      end
      S_ROW: begin
        dist_raddr_a = {from_index, via_index};
        state_next   = S_RELAX;
      end
      S_RELAX: begin
        relax_issue  = 1'b1;
        dist_raddr_a = {from_index, to_index};
        if (to_index == last_idx) begin
          to_index_next = '0;
          if (from_index == last_idx) begin
            from_index_next = '0;
            if (via_index == last_idx) begin
              via_index_next = '0;
              state_next     = S_DRAIN;
            end else begin
              via_index_next = via_index + 1'b1;
              state_next     = S_ROW;
            end
          end else begin
            from_index_next = from_index + 1'b1;
            state_next      = S_ROW;
          end
        end else begin
          to_index_next = to_index + 1'b1;
        end
      end
      S_DRAIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // write-back of copy or relaxation, in the cycle after the read was issued
  assign dist_we    = st_copy || (st_relax && relax_take);
  assign dist_waddr = st_addr;
  assign dist_wdata = st_copy ? {{(DIST_W - EDGE_W){edge_rd_a[EDGE_W-1]}}, edge_rd_a}
                              : relax_new;

  apsp_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (DEPTH)
  ) u_edge_ram (
    .clk     (clk),
    .we      (edge_we),
    .waddr   (edge_waddr),
    .wdata   (edge_wdata),
    .raddr_a ({from_index, to_index}),
    .rdata_a (edge_rd_a),
    .raddr_b ({row_idx, col_idx}),
    .rdata_b (edge_rd_b)
  );

  apsp_ram #(
    .WIDTH (DIST_W),
    .DEPTH (DEPTH)
  ) u_dist_ram (
    .clk     (clk),
    .we      (dist_we),
    .waddr   (dist_waddr),
    .wdata   (dist_wdata),
    .raddr_a (dist_raddr_a),
    .rdata_a (dist_rd_a),
    .raddr_b ({via_index, to_index}),
    .rdata_b (dist_rd_b)
  );

  apsp_relax u_relax (
    .dik     (dik),
    .dkj     ($signed(dist_rd_b)),
    .dij     ($signed(dist_rd_a)),
    .take    (relax_take),
    .new_val (relax_new)
  );

  assign valid = rd_valid;

  always_comb begin
    if (!rd_inside) begin
      value = '0;
    end else if (rd_dist) begin
      value = $signed(dist_rd_a);
    end else begin
      value = $signed({{(DIST_W - EDGE_W){edge_rd_b[EDGE_W-1]}}, edge_rd_b});
    end
  end

  // a result only follows an accepted read item
  assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(start && !busy && (opcode == OP_READ_DIST || opcode == OP_READ_EDGE)))
    else $error("result strobe without a read item");

  // no distance write may be left over once the block is idle
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !dist_we)
    else $error("distance write while idle");

  // loop counters stay within the active vertex count during a run
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RELAX || state == S_ROW) |->
      (via_index <= last_idx && from_index <= last_idx && to_index <= last_idx))
    else $error("run index beyond vertex count");

  // d[i][k] is fetched right before each row of relaxations
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RELAX && $past(state) != S_RELAX) |-> load_dik)
    else $error("row started without d[i][k]");

endmodule

`default_nettype wire

[tb/tb_all_pairs_shortest_path_top.sv]
// ----------------------------------------------------------------------------
// tb_all_pairs_shortest_path_top
// Self-checking bench for the Floyd-Warshall block: mirrors the edge and
// distance memories, predicts every read and compares it on the value strobe.
// ----------------------------------------------------------------------------
module tb_all_pairs_shortest_path_top;
  timeunit 1ns;
  timeprecision 1ps;

  import apsp_pkg::*;

  localparam int MAX_V        = 32;
  localparam int RANDOM_ITEMS = 1600;
  localparam int IDLE_LIMIT   = 100000;
  localparam int SETTLE       = 4;

  // opcodes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  logic                        clk;
  logic                        rst       = 1'b1;
  logic                        start     = 1'b0;
  logic                        busy;
  logic [OP_W-1:0]             opcode    = '0;
  logic [PIDX_W-1:0]           row       = '0;
  logic [PIDX_W-1:0]           col       = '0;
  logic signed [EDGE_W-1:0]    weight    = '0;
  logic                        valid;
  logic signed [DIST_W-1:0]    value;
  logic                        cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]            cfg_data  = '0;

  // mirror of the block's state and registers
  logic signed [EDGE_W-1:0] edge_mem [MAX_V*MAX_V];
  logic signed [DIST_W-1:0] dist_mem [MAX_V*MAX_V];
  logic [VC_W-1:0]          vc_cfg      = VC_RESET;
  logic signed [EDGE_W-1:0] no_edge_cfg = NO_EDGE_RESET;

  logic signed [DIST_W-1:0] value_due [$];
  int errors     = 0;
  int items_sent = 0;
  int burst_left = 0;

  all_pairs_shortest_path_top uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin : check_values
    logic signed [DIST_W-1:0] want;
    if (!rst && valid) begin
      if (value_due.size() == 0) begin
        $error("value: expected none, got %0d", value);
        errors++;
      end else begin
        want = value_due.pop_front();
        if (value !== want) begin
          $error("value: expected %0d, got %0d", want, value);
          errors++;
        end
      end
    end
  end

  function automatic int active_vertices();
    return (vc_cfg > VC_W'(MAX_V)) ? MAX_V : int'(vc_cfg);
  endfunction

  // applies one accepted item to the mirror and queues the value a read returns
  function automatic void apply_to_graph(logic [OP_W-1:0] op, logic [PIDX_W-1:0] r,
                                         logic [PIDX_W-1:0] c,
                                         logic signed [EDGE_W-1:0] w);
    int n, i, j, k, s;
    logic [2*PIDX_W-1:0] at;
    logic signed [DIST_W-1:0] v;
    n  = active_vertices();
    at = {r, c};
    case (op)
      OP_CLEAR: begin
        for (i = 0; i < n; i++)
          for (j = 0; j < n; j++)
            edge_mem[i*MAX_V+j] = (i == j) ? '0 : no_edge_cfg;
      end
      OP_SET_EDGE: edge_mem[at] = w;
      OP_RUN: begin
        for (i = 0; i < n; i++)
          for (j = 0; j < n; j++)
            dist_mem[i*MAX_V+j] = DIST_W'(edge_mem[i*MAX_V+j]);
        for (k = 0; k < n; k++)
          for (i = 0; i < n; i++)
            for (j = 0; j < n; j++) begin
              s = int'(dist_mem[i*MAX_V+k]) + int'(dist_mem[k*MAX_V+j]);
              if (s > int'(DIST_MAX)) s = int'(DIST_MAX);
              if (s < int'(DIST_MIN)) s = int'(DIST_MIN);
              if (s < int'(dist_mem[i*MAX_V+j])) dist_mem[i*MAX_V+j] = DIST_W'(s);
            end
      end
      OP_READ_DIST: value_due.push_back(dist_mem[at]);
      OP_READ_EDGE: begin
        v = DIST_W'(edge_mem[at]);
        value_due.push_back(v);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [PIDX_W-1:0] r,
                           input logic [PIDX_W-1:0] c,
                           input logic signed [EDGE_W-1:0] w);
    int gap;
    @(negedge clk);
    start  <= 1'b1;
    opcode <= op;
    row    <= r;
    col    <= c;
    weight <= w;
    do @(posedge clk); while (busy);
    apply_to_graph(op, r, c, w);
    if (op <= OP_READ_EDGE) items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      // mostly short bursts, now and then a long stretch without gaps
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 128)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_VERTEX_COUNT) vc_cfg = data[VC_W-1:0];
    else no_edge_cfg = data;
  endtask

  // drop start, then wait for every due read and for a clear or run to finish
  task automatic wait_idle();
    int waited;
    waited = 0;
    @(negedge clk);
    start <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while ((value_due.size() != 0 || busy) && waited < IDLE_LIMIT);
    if (waited >= IDLE_LIMIT) begin
      $error("value: %0d reads still without a result", value_due.size());
      errors++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [PIDX_W-1:0] pick_vertex(int n);
    return PIDX_W'((n > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, n - 1)
                                                        : $urandom_range(0, MAX_V - 1));
  endfunction

  function automatic logic signed [EDGE_W-1:0] pick_weight(bit neg_ok);
    case ($urandom_range(0, 9))
      0: return neg_ok ? 16'sh8000 : 16'sh7FFF;
      1: return 16'sh7FFF;
      2: return neg_ok ? EDGE_W'($urandom) : EDGE_W'($urandom_range(0, 32767));
      3: return neg_ok ? EDGE_W'(-int'($urandom_range(1, 30))) : '0;
      default: return EDGE_W'($urandom_range(0, 100));
    endcase
  endfunction

  // full-size clear with the reset registers writes every entry of the edge memory, the run then every distance entry
  task automatic test_reset_defaults();
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_READ_EDGE, 5'd0, 5'd1, '0);
    send_item(OP_RUN, '1, '1, '1);
    send_item(OP_READ_DIST, 5'd31, 5'd30, '0);
  endtask

  task automatic test_edge_extremes();
    send_item(OP_SET_EDGE, 5'd0, 5'd31, 16'sh8000);
    send_item(OP_SET_EDGE, 5'd31, 5'd0, 16'sh7FFF);
    send_item(OP_SET_EDGE, 5'd31, 5'd31, -16'sd1);
    send_item(OP_SPARE_A, '1, '1, '1);
    send_item(OP_READ_EDGE, 5'd0, 5'd31, '1);
    send_item(OP_SPARE_B, '0, '1, '0);
    send_item(OP_READ_EDGE, 5'd31, 5'd0, '0);
    send_item(OP_SPARE_C, '1, '0, 16'sh5555);
    send_item(OP_READ_EDGE, 5'd31, 5'd31, '0);
  endtask

  // every pair is a negative cycle, sums run into the lower saturation bound
  task automatic test_negative_cycles();
    wait_idle();
    write_reg(REG_NO_EDGE_WEIGHT, 16'h8000);
    write_reg(REG_VERTEX_COUNT, 16'd8);
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_RUN, '0, '0, '0);
    send_item(OP_READ_DIST, 5'd0, 5'd7, '0);
    send_item(OP_READ_DIST, 5'd7, 5'd7, '0);
  endtask

  task automatic test_vertex_count_limits();
    wait_idle();
    write_reg(REG_VERTEX_COUNT, 16'd0);
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_RUN, '0, '0, '0);
    send_item(OP_READ_EDGE, 5'd1, 5'd2, '0);
    send_item(OP_READ_DIST, 5'd1, 5'd2, '0);
    wait_idle();
    // above the store size: clear and run cover all vertices
    write_reg(REG_VERTEX_COUNT, 16'd63);
    write_reg(REG_NO_EDGE_WEIGHT, 16'h7FFF);
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_RUN, '0, '0, '0);
    send_item(OP_READ_EDGE, 5'd31, 5'd0, '0);
    send_item(OP_READ_DIST, 5'd31, 5'd0, '0);
  endtask

  // each phase: new registers, maybe a clear, a batch of edges, maybe a run, reads
  task automatic test_random_phases();
    int n, pick, big_left;
    bit neg_ok;
    logic [CFG_W-1:0] cfg;
    logic [OP_W-1:0] op;
    big_left = 3;
    while (items_sent < RANDOM_ITEMS) begin
      wait_idle();
      pick = $urandom_range(0, 99);
      if (pick < 4) n = 0;
      else if (pick < 10) n = 1;
      else if (pick < 12 && big_left > 0) begin
        n = $urandom_range(MAX_V, 63);
        big_left--;
      end else n = $urandom_range(2, 10);
      // bits above the vertex count are don't-care
      cfg = CFG_W'($urandom);
      cfg[VC_W-1:0] = VC_W'(n);
      write_reg(REG_VERTEX_COUNT, cfg);
      case ($urandom_range(0, 3))
        0: cfg = 16'h8000;
        1: cfg = 16'h7FFF;
        2: cfg = CFG_W'($urandom_range(0, 300));
        default: cfg = CFG_W'($urandom);
      endcase
      write_reg(REG_NO_EDGE_WEIGHT, cfg);
      n = active_vertices();
      neg_ok = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 3) != 0) begin
        send_item(OP_CLEAR, PIDX_W'($urandom), PIDX_W'($urandom), EDGE_W'($urandom));
      end
      repeat ($urandom_range(1, 2*n + 2)) begin
        if ($urandom_range(0, 11) == 0) begin
          op = OP_W'($urandom_range(OP_CLEAR, OP_SPARE_C));
          if (op == OP_RUN) op = OP_SET_EDGE;
          send_item(op, PIDX_W'($urandom), PIDX_W'($urandom), EDGE_W'($urandom));
        end else begin
          send_item(OP_SET_EDGE, pick_vertex(n), pick_vertex(n), pick_weight(neg_ok));
        end
      end
      if ($urandom_range(0, 9) != 0) begin
        send_item(OP_RUN, PIDX_W'($urandom), PIDX_W'($urandom), EDGE_W'($urandom));
      end
      repeat ($urandom_range(3, 14)) begin
        op = ($urandom_range(0, 3) == 0) ? OP_READ_EDGE : OP_READ_DIST;
        send_item(op, pick_vertex(n), pick_vertex(n), EDGE_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_edge_extremes();
    test_negative_cycles();
    test_vertex_count_limits();
    test_random_phases();
    wait_idle();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
rtl/apsp_pkg.sv
rtl/apsp_ram.sv
rtl/apsp_relax.sv
rtl/all_pairs_shortest_path_top.sv
tb/tb_all_pairs_shortest_path_top.sv
